// File: rtl/core/kmc_pkg.sv
`timescale 1ns / 1ps

package kmc_pkg;

    localparam int COORD_BITS   = 16;
    localparam int MAX_CLUSTERS = 16;
    localparam int KB           = $clog2(MAX_CLUSTERS);
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int PC_W         = 11;
    localparam int KC_W         = 5;
    localparam int EL_W         = 8;

    localparam logic [2:0] OP_LOAD_PT = 3'd0;
    localparam logic [2:0] OP_LOAD_CT = 3'd1;
    localparam logic [2:0] OP_RUN     = 3'd2;
    localparam logic [2:0] OP_READ_PT = 3'd3;
    localparam logic [2:0] OP_READ_CT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EPOCH_LIMIT   = 2'd2;

    typedef struct packed {
        logic [2:0]                   op;
        logic [9:0]                   slot;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
    } t_req;

    typedef struct packed {
        logic [KB-1:0]                cluster_id;
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic [EL_W-1:0]              epochs_run;
        logic                         converged;
    } t_rsp;

endpackage

// File: rtl/core/kmeans_2d_clustering.sv
`timescale 1ns / 1ps
// load, read-centroid, unknown requests: strobe in the cycle after start, one per cycle
// read-point request: label memory read, then centroid select, then registered result strobe
// run: per epoch a distance pass, then serial divides per cluster; SW = 27 at default size
// result strobe lasts one cycle, cannot be stalled; busy, if raised, is high until it shows
// synchronous reset starts a label clearing pass over all MAX_POINTS labels with busy high
module kmeans_2d_clustering import kmc_pkg::*; #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_req                 i_req,
    output logic                 busy,
    output logic                 o_strobe,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CB  = COORD_BITS;
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int NW  = AW + 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int SW  = CB + AW + 1;
    localparam int DW  = 2 * (CB + 1);
    localparam int DCW = $clog2(SW);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_RDLBL = 10'b0000000100,
        S_PTRD  = 10'b0000001000,
        S_DIST  = 10'b0000010000,
        S_DRAIN = 10'b0000100000,
        S_ACC   = 10'b0001000000,
        S_UPD   = 10'b0010000000,
        S_DIV   = 10'b0100000000,
        S_UPW   = 10'b1000000000
    } t_state;

    t_state r_state;

    logic [2*CB-1:0] pt_mem [MAX_POINTS];
    logic [KB-1:0]   lbl_mem [MAX_POINTS];
    logic [2*CB-1:0] r_pt_q;
    logic [KB-1:0]   r_lbl_q;

    logic signed [CB-1:0] r_cx [MAX_CLUSTERS];
    logic signed [CB-1:0] r_cy [MAX_CLUSTERS];
    logic signed [SW-1:0] r_sx [MAX_CLUSTERS];
    logic signed [SW-1:0] r_sy [MAX_CLUSTERS];
    logic [CW-1:0]        r_cnt [MAX_CLUSTERS];

    logic [PC_W-1:0] r_pc;
    logic [KC_W-1:0] r_kc;
    logic [EL_W-1:0] r_el;
    logic [EL_W-1:0] r_last_ep;
    logic            r_last_conv;

    logic [AW-1:0]   r_i;
    logic [KB-1:0]   r_j;
    logic [KB-1:0]   r_jd;
    logic            r_vd;
    logic [DW-1:0]   r_sqx;
    logic [DW-1:0]   r_sqy;
    logic [DW:0]     r_best;
    logic [KB-1:0]   r_bj;
    logic [EL_W-1:0] r_ep;
    logic            r_moved;
    logic            r_skip;
    logic            r_neg_x;
    logic            r_neg_y;
    logic [SW-1:0]   r_qx;
    logic [SW-1:0]   r_qy;
    logic [CW-1:0]   r_rx;
    logic [CW-1:0]   r_ry;
    logic [CW-1:0]   r_dd;
    logic [DCW-1:0]  r_dc;
    logic            r_strobe;
    t_rsp            r_rsp;

    logic            n_strobe;
    logic            acc;
    logic [AW-1:0]   slot_addr;
    logic            slot_ct_ok;
    logic [NW-1:0]   np;
    logic [KB:0]     nc;
    logic [AW-1:0]   i_last;
    logic [KB-1:0]   j_last;
    logic [EL_W-1:0] lim;
    logic [KB-1:0]   c_sel;
    logic signed [CB-1:0] cx_sel;
    logic signed [CB-1:0] cy_sel;
    logic signed [CB-1:0] px;
    logic signed [CB-1:0] py;
    logic signed [CB:0]   dx;
    logic signed [CB:0]   dy;
    logic [CB:0]     ax;
    logic [CB:0]     ay;
    logic [DW:0]     dsum;
    logic            lbl_we;
    logic [KB-1:0]   lbl_wd;
    logic [CW:0]     tx;
    logic [CW:0]     ty;
    logic            gx;
    logic            gy;
    logic [CW:0]     sx_rem;
    logic [CW:0]     sy_rem;
    logic [SW-1:0]   mx;
    logic [SW-1:0]   my;
    logic signed [CB-1:0] nx;
    logic signed [CB-1:0] ny;
    logic            chg;
    logic            mv;
    logic signed [SW-1:0] cur_sx;
    logic signed [SW-1:0] cur_sy;

    assign acc        = start && (r_state == S_IDLE);
    assign busy       = (r_state != S_IDLE);
    assign o_strobe   = r_strobe;
    assign o_rsp      = r_rsp;
    assign slot_addr  = AW'(32'(i_req.slot) & (MAX_POINTS - 1));
    assign slot_ct_ok = (32'(i_req.slot) < MAX_CLUSTERS);

    // run-time saturation of the count registers
    always_comb begin
        if (r_pc == '0) begin
            np = NW'(1);
        end else if (32'(r_pc) > MAX_POINTS) begin
            np = NW'(MAX_POINTS);
        end else begin
            np = NW'(r_pc);
        end
        if (r_kc == '0) begin
            nc = (KB+1)'(1);
        end else if (32'(r_kc) > MAX_CLUSTERS) begin
            nc = (KB+1)'(MAX_CLUSTERS);
        end else begin
            nc = (KB+1)'(r_kc);
        end
        lim = (r_el == '0) ? EL_W'(1) : r_el;
    end

    assign i_last = AW'(np - NW'(1));
    assign j_last = KB'(nc - (KB+1)'(1));

    always_comb begin
        case (r_state)
            S_IDLE:  c_sel = i_req.slot[KB-1:0];
            S_RDLBL: c_sel = r_lbl_q;
            default: c_sel = r_j;
        endcase
    end

    assign cx_sel = r_cx[c_sel];
    assign cy_sel = r_cy[c_sel];
    assign px     = r_pt_q[2*CB-1:CB];
    assign py     = r_pt_q[CB-1:0];
    assign dx     = {px[CB-1], px} - {cx_sel[CB-1], cx_sel};
    assign dy     = {py[CB-1], py} - {cy_sel[CB-1], cy_sel};
    assign ax     = dx[CB] ? (CB+1)'(-dx) : dx;
    assign ay     = dy[CB] ? (CB+1)'(-dy) : dy;
    assign dsum   = {1'b0, r_sqx} + {1'b0, r_sqy};

    assign lbl_we = (r_state == S_CLEAR) || (r_state == S_ACC);
    assign lbl_wd = (r_state == S_ACC) ? r_bj : '0;

    // restoring divider step, x and y lanes side by side
    assign tx     = {r_rx, r_qx[SW-1]};
    assign ty     = {r_ry, r_qy[SW-1]};
    assign gx     = (tx >= {1'b0, r_dd});
    assign gy     = (ty >= {1'b0, r_dd});
    assign sx_rem = gx ? (tx - {1'b0, r_dd}) : tx;
    assign sy_rem = gy ? (ty - {1'b0, r_dd}) : ty;

    assign mx  = r_neg_x ? (SW'(0) - r_qx) : r_qx;
    assign my  = r_neg_y ? (SW'(0) - r_qy) : r_qy;
    assign nx  = mx[CB-1:0];
    assign ny  = my[CB-1:0];
    assign chg = !r_skip && ((nx != cx_sel) || (ny != cy_sel));
    assign mv  = r_moved || chg;

    assign cur_sx = r_sx[r_j];
    assign cur_sy = r_sy[r_j];

    // result strobe for the next cycle
    assign n_strobe = ((r_state == S_IDLE) && start && (i_req.op != OP_RUN) &&
                       (i_req.op != OP_READ_PT)) ||
                      (r_state == S_RDLBL) ||
                      ((r_state == S_UPW) && (r_j == j_last) && !(mv && (r_ep < lim)));

    // point and label memories, registered read
    always_ff @(posedge i_clk) begin
        if (acc && (i_req.op == OP_LOAD_PT)) begin
            pt_mem[slot_addr] <= {i_req.coord_x, i_req.coord_y};
        end
        r_pt_q <= pt_mem[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (lbl_we) begin
            lbl_mem[r_i] <= lbl_wd;
        end
        r_lbl_q <= lbl_mem[slot_addr];
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_sqx <= DW'(ax * ax);
        r_sqy <= DW'(ay * ay);
        r_jd  <= r_j;
        if (r_vd && ((r_jd == '0) || (dsum <= r_best))) begin
            r_best <= dsum;
            r_bj   <= r_jd;
        end
        if (acc && (i_req.op == OP_LOAD_CT) && slot_ct_ok) begin
            r_cx[i_req.slot[KB-1:0]] <= i_req.coord_x;
            r_cy[i_req.slot[KB-1:0]] <= i_req.coord_y;
        end
        if ((r_state == S_UPW) && chg) begin
            r_cx[r_j] <= nx;
            r_cy[r_j] <= ny;
        end
        if (r_state == S_UPD) begin
            r_neg_x <= cur_sx[SW-1];
            r_neg_y <= cur_sy[SW-1];
            r_qx    <= cur_sx[SW-1] ? (SW'(0) - cur_sx) : cur_sx;
            r_qy    <= cur_sy[SW-1] ? (SW'(0) - cur_sy) : cur_sy;
            r_rx    <= '0;
            r_ry    <= '0;
            r_dd    <= r_cnt[r_j];
            r_dc    <= '0;
        end else if (r_state == S_DIV) begin
            r_qx <= {r_qx[SW-2:0], gx};
            r_qy <= {r_qy[SW-2:0], gy};
            r_rx <= sx_rem[CW-1:0];
            r_ry <= sy_rem[CW-1:0];
            r_dc <= r_dc + DCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_i         <= '0;
            r_j         <= '0;
            r_vd        <= 1'b0;
            r_pc        <= PC_W'(1);
            r_kc        <= KC_W'(1);
            r_el        <= EL_W'(1);
            r_last_ep   <= '0;
            r_last_conv <= 1'b0;
            r_ep        <= '0;
            r_moved     <= 1'b0;
            r_skip      <= 1'b0;
            r_strobe    <= 1'b0;
            r_rsp       <= '0;
            for (int k = 0; k < MAX_CLUSTERS; k++) begin
                r_sx[k]  <= '0;
                r_sy[k]  <= '0;
                r_cnt[k] <= '0;
            end
        end else begin
            r_strobe <= n_strobe;
            r_vd     <= (r_state == S_DIST);

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_POINT_COUNT:   r_pc <= i_cfg_data[PC_W-1:0];
                    REG_CLUSTER_COUNT: r_kc <= i_cfg_data[KC_W-1:0];
                    REG_EPOCH_LIMIT:   r_el <= i_cfg_data[EL_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_i <= (r_i == AW'(MAX_POINTS - 1)) ? '0 : r_i + AW'(1);
                    if (r_i == AW'(MAX_POINTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        unique case (i_req.op)
                            OP_RUN: begin
                                r_ep    <= EL_W'(1);
                                r_moved <= 1'b0;
                                r_i     <= '0;
                                r_state <= S_PTRD;
                            end
                            OP_READ_PT: begin
                                r_state <= S_RDLBL;
                            end
                            OP_READ_CT: begin
                                if (slot_ct_ok) begin
                                    r_rsp <= '{cluster_id: i_req.slot[KB-1:0], out_x: cx_sel,
                                               out_y: cy_sel, epochs_run: r_last_ep,
                                               converged: r_last_conv};
                                end else begin
                                    r_rsp <= '{cluster_id: '0, out_x: '0, out_y: '0,
                                               epochs_run: r_last_ep, converged: r_last_conv};
                                end
                            end
                            default: begin
                                r_rsp <= '{cluster_id: '0, out_x: '0, out_y: '0,
                                           epochs_run: r_last_ep, converged: r_last_conv};
                            end
                        endcase
                    end
                end
                S_RDLBL: begin
                    r_rsp   <= '{cluster_id: r_lbl_q, out_x: cx_sel, out_y: cy_sel,
                                 epochs_run: r_last_ep, converged: r_last_conv};
                    r_state <= S_IDLE;
                end
                S_PTRD: begin
                    r_j     <= '0;
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    r_j <= r_j + KB'(1);
                    if (r_j == j_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sx[r_bj]  <= r_sx[r_bj] + {{(SW-CB){px[CB-1]}}, px};
                    r_sy[r_bj]  <= r_sy[r_bj] + {{(SW-CB){py[CB-1]}}, py};
                    r_cnt[r_bj] <= r_cnt[r_bj] + CW'(1);
                    if (r_i == i_last) begin
                        r_j     <= '0;
                        r_state <= S_UPD;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_PTRD;
                    end
                end
                S_UPD: begin
                    // empty cluster keeps its centroid
                    if (r_cnt[r_j] == '0) begin
                        r_skip  <= 1'b1;
                        r_state <= S_UPW;
                    end else begin
                        r_skip  <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_dc == DCW'(SW - 1)) begin
                        r_state <= S_UPW;
                    end
                end
                S_UPW: begin
                    r_sx[r_j]  <= '0;
                    r_sy[r_j]  <= '0;
                    r_cnt[r_j] <= '0;
                    if (r_j == j_last) begin
                        if (mv && (r_ep < lim)) begin
                            r_ep    <= r_ep + EL_W'(1);
                            r_moved <= 1'b0;
                            r_i     <= '0;
                            r_state <= S_PTRD;
                        end else begin
                            r_moved     <= mv;
                            r_last_ep   <= r_ep;
                            r_last_conv <= !mv;
                            r_rsp       <= '{cluster_id: '0, out_x: '0, out_y: '0,
                                             epochs_run: r_ep, converged: !mv};
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_moved <= mv;
                        r_j     <= r_j + KB'(1);
                        r_state <= S_UPD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/kmc_checker.sv
`timescale 1ns / 1ps
module kmc_props import kmc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic i_busy,
    input logic i_strobe,
    input t_req i_req
);

    logic acc;
    assign acc = i_start && !i_busy;

    // reset always begins with the label clearing pass
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> i_busy && !i_strobe)
        else $error("block not busy after reset");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe |-> !i_busy)
        else $error("result shown while busy");

    a_short_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_req.op == OP_LOAD_PT || i_req.op == OP_LOAD_CT ||
                i_req.op == OP_READ_CT || i_req.op > OP_READ_CT) |=> i_strobe)
        else $error("load or centroid read result missing");

    a_read_pt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_req.op == OP_READ_PT) |=> i_busy && !i_strobe ##1 i_strobe)
        else $error("point read result not two cycles after request");

    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_req.op == OP_RUN) |=> i_busy && !i_strobe)
        else $error("run did not hold the block busy");

endmodule

bind kmeans_2d_clustering kmc_props u_kmc_props (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (start),
    .i_busy   (busy),
    .i_strobe (o_strobe),
    .i_req    (i_req)
);

// File: test/kmc_checker.sv
`timescale 1ns / 1ps

module kmc_checker import kmc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  t_req                 i_req,
    input  logic                 o_strobe,
    input  t_rsp                 o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    localparam int NPTS = 1024;

    int pt_x [NPTS];
    int pt_y [NPTS];
    int pt_label [NPTS];
    int ct_x [MAX_CLUSTERS];
    int ct_y [MAX_CLUSTERS];
    int pt_cnt, cl_cnt, ep_lim;
    int last_ep;
    bit last_conv;
    t_rsp rsp_fifo[$];

    assign o_pending = rsp_fifo.size();

    task automatic report_mismatch(input string msg);
        $display("kmc_checker: mismatch at %0t: %s", $realtime, msg);
        o_errors++;
    endtask

    // lloyd iterations over the loaded prefix
    task automatic run_lloyd();
        int np, nc, lim, ep, best, cnt;
        bit moved;
        longint d, bd, dx, dy, nx, ny;
        longint sx [MAX_CLUSTERS];
        longint sy [MAX_CLUSTERS];
        int members [MAX_CLUSTERS];
        np = (pt_cnt < 1) ? 1 : (pt_cnt > NPTS) ? NPTS : pt_cnt;
        nc = (cl_cnt < 1) ? 1 : (cl_cnt > MAX_CLUSTERS) ? MAX_CLUSTERS : cl_cnt;
        lim = (ep_lim < 1) ? 1 : ep_lim;
        ep = 0;
        do begin
            ep++;
            for (int j = 0; j < MAX_CLUSTERS; j++) begin
                sx[j] = 0;
                sy[j] = 0;
                members[j] = 0;
            end
            for (int i = 0; i < np; i++) begin
                best = 0;
                bd = 0;
                for (int j = 0; j < nc; j++) begin
                    dx = longint'(pt_x[i]) - ct_x[j];
                    dy = longint'(pt_y[i]) - ct_y[j];
                    d = dx * dx + dy * dy;
                    // ties go to the higher index
                    if (j == 0 || d <= bd) begin
                        best = j;
                        bd = d;
                    end
                end
                pt_label[i] = best;
                sx[best] += pt_x[i];
                sy[best] += pt_y[i];
                members[best]++;
            end
            moved = 0;
            for (int j = 0; j < nc; j++) begin
                cnt = members[j];
                if (cnt != 0) begin
                    nx = sx[j] / cnt;
                    ny = sy[j] / cnt;
                    if (nx != ct_x[j] || ny != ct_y[j]) begin
                        moved = 1;
                        ct_x[j] = int'(nx);
                        ct_y[j] = int'(ny);
                    end
                end
            end
        end while (moved && ep < lim);
        last_ep = ep & 8'hff;
        last_conv = !moved;
    endtask

    function automatic t_rsp predict_request(input t_req r);
        t_rsp e;
        int c;
        e = '0;
        case (r.op)
            OP_LOAD_PT: begin
                pt_x[r.slot] = r.coord_x;
                pt_y[r.slot] = r.coord_y;
            end
            OP_LOAD_CT: begin
                if (r.slot < MAX_CLUSTERS) begin
                    ct_x[r.slot] = r.coord_x;
                    ct_y[r.slot] = r.coord_y;
                end
            end
            OP_READ_PT: begin
                c = pt_label[r.slot] % MAX_CLUSTERS;
                e.cluster_id = c[KB-1:0];
                e.out_x = ct_x[c][COORD_BITS-1:0];
                e.out_y = ct_y[c][COORD_BITS-1:0];
            end
            OP_READ_CT: begin
                if (r.slot < MAX_CLUSTERS) begin
                    e.cluster_id = r.slot[KB-1:0];
                    e.out_x = ct_x[r.slot][COORD_BITS-1:0];
                    e.out_y = ct_y[r.slot][COORD_BITS-1:0];
                end
            end
            default: ;
        endcase
        return e;
    endfunction

    always @(posedge i_clk) begin
        t_rsp e;
        if (!i_rst_n) begin
            pt_cnt <= 1;
            cl_cnt <= 1;
            ep_lim <= 1;
            last_ep = 0;
            last_conv = 0;
            for (int i = 0; i < NPTS; i++) pt_label[i] = 0;
            rsp_fifo.delete();
        end else begin
            if (o_strobe) begin
                if (rsp_fifo.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    e = rsp_fifo.pop_front();
                    if (o_rsp.cluster_id !== e.cluster_id)
                        report_mismatch($sformatf("cluster_id %0d exp %0d",
                                        o_rsp.cluster_id, e.cluster_id));
                    if (o_rsp.out_x !== e.out_x)
                        report_mismatch($sformatf("out_x %0d exp %0d", o_rsp.out_x, e.out_x));
                    if (o_rsp.out_y !== e.out_y)
                        report_mismatch($sformatf("out_y %0d exp %0d", o_rsp.out_y, e.out_y));
                    if (o_rsp.epochs_run !== e.epochs_run)
                        report_mismatch($sformatf("epochs_run %0d exp %0d",
                                        o_rsp.epochs_run, e.epochs_run));
                    if (o_rsp.converged !== e.converged)
                        report_mismatch($sformatf("converged %0b exp %0b",
                                        o_rsp.converged, e.converged));
                end
            end
            if (start && !busy) begin
                e = predict_request(i_req);
                if (i_req.op == OP_RUN) run_lloyd();
                e.epochs_run = last_ep[EL_W-1:0];
                e.converged = last_conv;
                rsp_fifo.push_back(e);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_POINT_COUNT:   pt_cnt <= i_cfg_data[PC_W-1:0];
                    REG_CLUSTER_COUNT: cl_cnt <= i_cfg_data[KC_W-1:0];
                    REG_EPOCH_LIMIT:   ep_lim <= i_cfg_data[EL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    initial o_errors = 0;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import kmc_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int NPTS = 1024;
    localparam int ITEM_TARGET = 1550;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    t_req i_req = '0;
    logic busy, o_strobe;
    t_rsp o_rsp;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    int errors, pending;

    int n_items;
    bit idle_ok;
    bit all_loaded;
    int np, nc, el, np_load, cx0, cy0;

    always #1 i_clk = ~i_clk;

    kmeans_2d_clustering dut (.*);

    kmc_checker chk (
        .i_clk, .i_rst_n, .start, .busy, .i_req, .o_strobe, .o_rsp,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    task automatic issue(input logic [2:0] op, input int slot, input int x, input int y);
        t_req r;
        r.op = op;
        r.slot = slot[9:0];
        r.coord_x = x[15:0];
        r.coord_y = y[15:0];
        if (idle_ok && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk) start <= 0;
            repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        n_items++;
    endtask

    task automatic drain();
        @(negedge i_clk) start <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CFG_W-1:0];
    endtask

    task automatic set_regs(input int p, input int c, input int e);
        cfg_write(REG_POINT_COUNT, p);
        // upper bits of the narrow registers are don't-care
        cfg_write(REG_CLUSTER_COUNT, ($urandom_range(0, 63) << KC_W) | c);
        cfg_write(REG_EPOCH_LIMIT, ($urandom_range(0, 7) << EL_W) | e);
        @(negedge i_clk) i_cfg_we <= 0;
    endtask

    function automatic int near_coord(input int ctr);
        int v;
        v = ctr + $signed($urandom_range(0, 4000)) - 2000;
        return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
    endfunction

    function automatic int any_coord();
        return $signed($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic noise();
        case ($urandom_range(0, 4))
            0: issue(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom_range(0, 1023),
                     any_coord(), any_coord());
            1: issue(OP_LOAD_CT, $urandom_range(16, 1023), any_coord(), any_coord());
            2: issue(OP_READ_CT, $urandom_range(0, 1023), any_coord(), any_coord());
            default: issue(OP_READ_PT, $urandom_range(0, 1023), any_coord(), any_coord());
        endcase
    endtask

    initial begin
        n_items = 0;
        idle_ok = 1;
        all_loaded = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1;

        // directed: extremes, every op, ignored and out-of-range slots
        for (int j = 0; j < MAX_CLUSTERS; j++)
            issue(OP_LOAD_CT, j, (j[0]) ? 32767 : -32768, (j[1]) ? 32767 : -32768);
        issue(OP_LOAD_PT, 0, -32768, -32768);
        issue(OP_LOAD_PT, 1023, 32767, 32767);
        issue(OP_READ_PT, 1023, 0, 0);
        issue(OP_RUN, 0, 0, 0);
        issue(OP_READ_PT, 0, 0, 0);
        issue(OP_READ_CT, 15, 0, 0);
        issue(OP_READ_CT, 1023, 0, 0);
        issue(OP_LOAD_CT, 1023, 1, 1);
        issue(OP_SPARE_LO, 0, 0, 0);
        issue(OP_SPARE_HI, 1023, -1, -1);

        for (int ph = 0; n_items < ITEM_TARGET; ph++) begin
            drain();
            if (ph == 0) begin
                np = NPTS;
                nc = MAX_CLUSTERS;
                el = 4;
            end else begin
                case ($urandom_range(0, 9))
                    0: np = 0;
                    1: np = $urandom_range(NPTS + 1, 2047);
                    2: np = 1;
                    default: np = $urandom_range(2, 40);
                endcase
                case ($urandom_range(0, 5))
                    0: nc = 0;
                    1: nc = $urandom_range(17, 31);
                    2: nc = MAX_CLUSTERS;
                    default: nc = $urandom_range(1, 8);
                endcase
                case ($urandom_range(0, 7))
                    0: el = 0;
                    1: el = 255;
                    default: el = $urandom_range(1, 20);
                endcase
                if (np > 40 && el > 4 || np > 40 && el == 0) el = $urandom_range(1, 4);
            end
            set_regs(np, nc, el);
            idle_ok = (n_items < ITEM_TARGET - 150);
            np_load = (np > NPTS && all_loaded) ? 0 : (np < 1) ? 1 :
                      (np > NPTS) ? NPTS : np;
            if (np_load == NPTS) all_loaded = 1;
            cx0 = any_coord();
            cy0 = any_coord();
            for (int i = 0; i < np_load; i++) begin
                if ($urandom_range(0, 9) == 0) noise();
                if ($urandom_range(0, 3) == 0) begin
                    cx0 = any_coord();
                    cy0 = any_coord();
                end
                if ($urandom_range(0, 7) == 0)
                    issue(OP_LOAD_PT, i, any_coord(), any_coord());
                else
                    issue(OP_LOAD_PT, i, near_coord(cx0), near_coord(cy0));
            end
            repeat ($urandom_range(0, 4)) begin
                // duplicate centroids now and then to force ties
                if ($urandom_range(0, 2) == 0)
                    issue(OP_LOAD_CT, $urandom_range(0, 15), cx0, cy0);
                else
                    issue(OP_LOAD_CT, $urandom_range(0, 15), any_coord(), any_coord());
            end
            issue(OP_RUN, $urandom_range(0, 1023), any_coord(), any_coord());
            repeat ($urandom_range(4, 14)) begin
                if ($urandom_range(0, 1) == 0)
                    issue(OP_READ_PT, $urandom_range(0, 1023), any_coord(), any_coord());
                else
                    issue(OP_READ_CT, $urandom_range(0, 20), any_coord(), any_coord());
            end
        end

        @(negedge i_clk) start <= 0;
        for (int k = 0; k < 200000 && pending != 0; k++) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
